// ----- rtl/double_ended_queue_macros.svh -----
// Assertion macros for the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, skipped while reset is high.
`define DEQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DEQ_ASSERT(lbl, clk, rst, prop, msg)
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/deq_pkg.sv -----
// Shared types and codes for the double-ended queue.
package deq_pkg;

  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_LOAD = 2'd2
  } state_t;

  localparam int unsigned IO_BITS = 32;

endpackage

// ----- rtl/deq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/double_ended_queue.sv -----
// Top level of the bounded double-ended queue kept in a ring buffer.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------------
//  input    | in_valid / in_ready     | op, value
//  output   | out_valid / out_ready   | front_word, back_word, is_empty_flag, status
//
// Each item goes through the accept step with the RAM write and pointer update,
// the read step that presents the new front and back addresses to the RAM read ports,
// and the load step that moves the registered read data into the output register.
// The registered RAM read makes the read step needed; one item is in flight at a time.
// Reset (rst, synchronous) empties the queue; RAM contents are not cleared.
// A stalled output holds the load step until the output register is free.
`include "double_ended_queue_macros.svh"

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] front_word,
  output logic signed [31:0] back_word,
  output logic               is_empty_flag,
  output logic [1:0]         status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  state_t state, state_next;

  // Ring pointers: front is the slot of the front word, back is one past the back word.
  logic [AW-1:0] front_index, front_index_next;
  logic [AW-1:0] back_index, back_index_next;
  logic [CW-1:0] occupancy, occupancy_next;
  status_t       op_status, op_status_next;

  logic                 accept;
  logic                 load;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        back_last;
  logic [WORD_BITS-1:0] front_rdata;
  logic [WORD_BITS-1:0] back_rdata;
  logic                 empty_now;

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST_SLOT : i - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + AW'(1);
  endfunction

  // Word to I/O width, sign-extended or cut.
  function automatic logic [IO_BITS-1:0] to_io(input logic [WORD_BITS-1:0] w);
    return IO_BITS'({{IO_BITS{w[WORD_BITS-1]}}, w});
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign back_last = ring_prev(back_index);
  assign empty_now = (occupancy == '0);

  // Incoming value cut to the stored width and sign-extended when wider.
  assign ram_wdata = WORD_BITS'({{WORD_BITS{value[31]}}, value});

  // Two copies of the ring so that front and back can be read in the same cycle.
  deq_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram_front (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (front_index),
    .rdata (front_rdata)
  );

  deq_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram_back (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (back_last),
    .rdata (back_rdata)
  );

  // Next state, pointer update and RAM write.
  always_comb begin
    state_next       = state;
    front_index_next = front_index;
    back_index_next  = back_index;
    occupancy_next   = occupancy;
    op_status_next   = op_status;
    ram_we           = 1'b0;
    ram_waddr        = back_index;
    load             = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next     = S_READ;
          op_status_next = ST_OK;
          case (op)
            OP_PUSH_FRONT: begin
              if (occupancy >= FULL_CNT) begin
                op_status_next = ST_OVERFLOW;
              end else begin
                front_index_next = ring_prev(front_index);
                ram_we           = 1'b1;
                ram_waddr        = ring_prev(front_index);
                occupancy_next   = occupancy + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (occupancy >= FULL_CNT) begin
                op_status_next = ST_OVERFLOW;
              end else begin
                ram_we          = 1'b1;
                ram_waddr       = back_index;
                back_index_next = ring_next(back_index);
                occupancy_next  = occupancy + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (empty_now) begin
                op_status_next = ST_UNDERFLOW;
              end else begin
                front_index_next = ring_next(front_index);
                occupancy_next   = occupancy - CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (empty_now) begin
                op_status_next = ST_UNDERFLOW;
              end else begin
                back_index_next = ring_prev(back_index);
                occupancy_next  = occupancy - CW'(1);
              end
            end
            default: begin
              // none and unused codes leave the queue alone
            end
          endcase
        end
      end
      S_READ: begin
        // RAM registers the words at the updated pointers this cycle
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      back_index  <= '0;
      occupancy   <= '0;
      op_status   <= ST_OK;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      back_index  <= back_index_next;
      occupancy   <= occupancy_next;
      op_status   <= op_status_next;
    end
  end

  // Output register; pointers are stable during the load step.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      front_word    <= empty_now ? '1 : to_io(front_rdata);
      back_word     <= empty_now ? '1 : to_io(back_rdata);
      is_empty_flag <= empty_now;
      status        <= op_status;
    end
  end

  `DEQ_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> (state == S_IDLE && !out_valid), "reset not idle")
  `DEQ_ASSERT(a_occ_bound, clk, rst, occupancy <= FULL_CNT, "occupancy above depth")
  `DEQ_ASSERT(a_empty_ptrs, clk, rst, empty_now |-> (front_index == back_index), "empty queue with split pointers")
  `DEQ_ASSERT(a_occ_hold, clk, rst, !accept |=> $stable(occupancy), "occupancy moved without an item")
  `DEQ_ASSERT(a_empty_words, clk, rst, (out_valid && is_empty_flag) |-> (front_word == -32'sd1 && back_word == -32'sd1), "empty result without all-ones words")

endmodule
